>>> hw/rtl/apsp_pkg.sv
`default_nettype none
package apsp_pkg;

  localparam int NODE_W   = 6;
  localparam int WEIGHT_W = 13;
  localparam int LEN_W    = 16;
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  // one stored edge
  typedef struct packed {
    logic [NODE_W-1:0]          tail;
    logic [NODE_W-1:0]          head;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

endpackage
`default_nettype wire

>>> hw/rtl/apsp_req_if.sv
`default_nettype none
interface apsp_req_if import apsp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [NODE_W-1:0]          from_node;
  logic [NODE_W-1:0]          to_node;
  logic signed [WEIGHT_W-1:0] edge_weight;
  logic                       last_edge;

  modport source (output valid, op, from_node, to_node, edge_weight, last_edge,
                  input ready);
  modport sink   (input valid, op, from_node, to_node, edge_weight, last_edge,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/apsp_rsp_if.sv
`default_nettype none
interface apsp_rsp_if import apsp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [NODE_W-1:0]       src_node;
  logic [NODE_W-1:0]       dest_node;
  logic signed [LEN_W-1:0] path_length;
  logic                    reachable;
  logic                    negative_cycle;

  modport source (output valid, kind, src_node, dest_node, path_length, reachable,
                  negative_cycle, input ready);
  modport sink   (input valid, kind, src_node, dest_node, path_length, reachable,
                  negative_cycle, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/all_pairs_shortest_path_core.sv
// All-pairs shortest path engine (Johnson's method). Edge requests (op 0) are
// stored one per cycle while ready is high; the edge flagged last_edge starts
// a run and the input stays stalled until a status response (kind 0,
// negative_cycle = outcome) is issued. A run is: clearing the potentials,
// n+1 Bellman-Ford passes (the last pass only checks for a negative cycle),
// then, unless a cycle was found, for each source a distance init, up to n
// rounds of (minimum scan + a relax step per edge), and a pass writing the
// matrix row. Every edge step is a read-modify-write of the potential or
// distance memory done to completion before the next edge is read, so no
// forwarding is needed. Query requests (op 1) are not taken back to back, as
// the result matrix read is registered. Unreachable pairs answer path_length
// 2^(DIST_WIDTH-1)-1 with reachable 0. No clearing pass after reset: the
// matrix is only defined after the first clean run.
`default_nettype none
module all_pairs_shortest_path_core import apsp_pkg::*; #(
  parameter int MAX_NODES  = 64,
  parameter int MAX_EDGES  = 1024,
  parameter int DIST_WIDTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  apsp_req_if.sink              req_i,
  apsp_rsp_if.source            rsp_o
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int CW  = (NCW > CFG_W) ? NCW : CFG_W;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int DW  = DIST_WIDTH;
  localparam int XW  = ((DW > WEIGHT_W) ? DW : WEIGHT_W) + 3;
  localparam int MW  = 2 * NW;

  localparam logic signed [DW-1:0] UNREACH = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN    = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b000000000001,
    ST_POT_INIT = 12'b000000000010,
    ST_BF_EDGE  = 12'b000000000100,
    ST_BF_POT   = 12'b000000001000,
    ST_BF_RELAX = 12'b000000010000,
    ST_SRC_INIT = 12'b000000100000,
    ST_SEL      = 12'b000001000000,
    ST_RX_EDGE  = 12'b000010000000,
    ST_RX_READ  = 12'b000100000000,
    ST_RX_RELAX = 12'b001000000000,
    ST_ROW      = 12'b010000000000,
    ST_DONE     = 12'b100000000000
  } state_e;

  // saturate a wide sum to the distance width
  function automatic logic signed [DW-1:0] sat(input logic signed [XW-1:0] x);
    logic signed [DW-1:0] r;
    if (x > XW'(UNREACH)) r = UNREACH;
    else if (x < XW'(DMIN)) r = DMIN;
    else r = DW'(x);
    return r;
  endfunction

  function automatic logic in_use(input logic [NODE_W-1:0] x, input logic [NCW-1:0] n);
    return CW'(x) < CW'(n);
  endfunction

  // control state
  state_e           state_q, state_d;
  logic [CFG_W-1:0] node_cfg_q;
  logic [NCW-1:0]   n_q, n_d;
  logic [ECW-1:0]   ecnt_q, ecnt_d;
  logic [ECW-1:0]   nedge_q, nedge_d;
  logic [ECW-1:0]   e_q, e_d;
  logic [NCW-1:0]   p_q, p_d;
  logic [NCW-1:0]   v_q, v_d;
  logic [NCW-1:0]   k_q, k_d;
  logic             cyc_q, cyc_d;
  logic             cycfound_q, cycfound_d;
  logic [NCW-1:0]   mat_n_q, mat_n_d;
  logic             best_vld_q, best_vld_d;
  logic [MAX_NODES-1:0] settled_q, settled_d;
  logic             q_pend_q, q_pend_d;
  logic             ov_q, ov_d;

  // payload state
  logic [NW-1:0]              s_q, s_d;
  logic [NW-1:0]              u_q, u_d;
  logic [NW-1:0]              best_v_q, best_v_d;
  logic signed [DW-1:0]       best_d_q, best_d_d;
  logic signed [DW-1:0]       wdu_q, wdu_d;
  logic [NW-1:0]              hd_q, hd_d;
  logic signed [WEIGHT_W-1:0] wt_q, wt_d;
  logic [NODE_W-1:0]          qa_q, qa_d, qb_q, qb_d;
  logic                       q_oor_q, q_oor_d;
  logic                       okind_q, okind_d;
  logic [NODE_W-1:0]          osrc_q, osrc_d, odst_q, odst_d;
  logic signed [LEN_W-1:0]    olen_q, olen_d;
  logic                       oreach_q, oreach_d, oneg_q, oneg_d;

  // memory ports
  logic                 pot_we;
  logic [NW-1:0]        pot_wa, pot_ra_a, pot_ra_b;
  logic signed [DW-1:0] pot_wdat, pot_rd_a_q, pot_rd_b_q;
  logic                 wd_we;
  logic [NW-1:0]        wd_wa, wd_ra;
  logic signed [DW-1:0] wd_wdat, wd_rd_q;
  logic                 mat_we;
  logic [MW-1:0]        mat_wa, mat_ra;
  logic signed [DW-1:0] mat_wdat, mat_rd_q;
  logic                 ewe;
  logic [EAW-1:0]       era;
  edge_t                ewdata, erd;

  logic signed [DW-1:0] pot_mem [MAX_NODES];
  logic signed [DW-1:0] wd_mem  [MAX_NODES];
  logic signed [DW-1:0] mat_mem [2**MW];

  logic                 rdy, acc;
  logic [NCW-1:0]       niu;
  logic [CW-1:0]        cfg_x;
  logic signed [XW-1:0] bf_cand;
  logic signed [DW-1:0] rx_wp, rx_cand, q_len;
  logic [NW-1:0]        vm1;
  logic                 ev, fin_vld;
  logic [NW-1:0]        fin_v;
  logic signed [DW-1:0] fin_d;

  apsp_edge_mem #(
    .DEPTH (MAX_EDGES),
    .AW    (EAW)
  ) u_edge_mem (
    .clk_i   (clk_i),
    .we_i    (ewe),
    .waddr_i (ecnt_q[EAW-1:0]),
    .wdata_i (ewdata),
    .raddr_i (era),
    .rdata_o (erd)
  );

  assign rdy = (state_q == ST_IDLE) && !q_pend_q && (!ov_q || rsp_o.ready);
  assign acc = req_i.valid && rdy;

  // node count clamped to 1..MAX_NODES
  assign cfg_x = CW'(node_cfg_q);
  always_comb begin
    if (cfg_x == '0) niu = NCW'(1);
    else if (cfg_x > CW'(MAX_NODES)) niu = NCW'(MAX_NODES);
    else niu = NCW'(cfg_x);
  end

  assign ewdata.tail   = req_i.from_node;
  assign ewdata.head   = req_i.to_node;
  assign ewdata.weight = req_i.edge_weight;
  assign ewe = acc && (req_i.op == OP_LOAD) && (ecnt_q < ECW'(MAX_EDGES));

  // arithmetic of the relax and scan steps
  assign bf_cand = XW'(pot_rd_a_q) + XW'(wt_q);
  assign rx_wp   = sat(XW'(wt_q) + XW'(pot_rd_a_q) - XW'(pot_rd_b_q));
  assign rx_cand = sat(XW'(wdu_q) + XW'(rx_wp));
  assign vm1     = NW'(v_q - NCW'(1));
  assign ev      = (v_q != '0) && !settled_q[vm1] && (wd_rd_q != UNREACH) &&
                   (!best_vld_q || (wd_rd_q < best_d_q));
  assign fin_vld = best_vld_q || ev;
  assign fin_v   = ev ? vm1 : best_v_q;
  assign fin_d   = ev ? wd_rd_q : best_d_q;
  assign q_len   = q_oor_q ? UNREACH : mat_rd_q;

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    ecnt_d     = ecnt_q;
    nedge_d    = nedge_q;
    e_d        = e_q;
    p_d        = p_q;
    v_d        = v_q;
    k_d        = k_q;
    cyc_d      = cyc_q;
    cycfound_d = cycfound_q;
    mat_n_d    = mat_n_q;
    best_vld_d = best_vld_q;
    settled_d  = settled_q;
    q_pend_d   = acc && (req_i.op == OP_QUERY);
    ov_d       = ov_q;
    s_d        = s_q;
    u_d        = u_q;
    best_v_d   = best_v_q;
    best_d_d   = best_d_q;
    wdu_d      = wdu_q;
    hd_d       = hd_q;
    wt_d       = wt_q;
    qa_d       = qa_q;
    qb_d       = qb_q;
    q_oor_d    = q_oor_q;
    okind_d    = okind_q;
    osrc_d     = osrc_q;
    odst_d     = odst_q;
    olen_d     = olen_q;
    oreach_d   = oreach_q;
    oneg_d     = oneg_q;

    pot_we   = 1'b0;
    pot_wa   = v_q[NW-1:0];
    pot_wdat = '0;
    pot_ra_a = s_q;
    pot_ra_b = v_q[NW-1:0];
    wd_we    = 1'b0;
    wd_wa    = v_q[NW-1:0];
    wd_wdat  = UNREACH;
    wd_ra    = v_q[NW-1:0];
    mat_we   = 1'b0;
    mat_wa   = {s_q, vm1};
    mat_wdat = UNREACH;
    mat_ra   = {NW'(req_i.from_node), NW'(req_i.to_node)};
    era      = e_q[EAW-1:0];

    if (ov_q && rsp_o.ready) ov_d = 1'b0;

    // query answer loaded in the cycle after the matrix read
    if (q_pend_q) begin
      ov_d     = 1'b1;
      okind_d  = KIND_ANSWER;
      osrc_d   = qa_q;
      odst_d   = qb_q;
      olen_d   = LEN_W'(q_len);
      oreach_d = (q_len != UNREACH);
      oneg_d   = cycfound_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (acc && (req_i.op == OP_QUERY)) begin
          qa_d    = req_i.from_node;
          qb_d    = req_i.to_node;
          q_oor_d = cycfound_q || !in_use(req_i.from_node, mat_n_q) ||
                    !in_use(req_i.to_node, mat_n_q);
        end else if (acc) begin
          if (ewe) ecnt_d = ecnt_q + ECW'(1);
          if (req_i.last_edge) begin
            nedge_d = ecnt_d;
            ecnt_d  = '0;
            n_d     = niu;
            cyc_d   = 1'b0;
            v_d     = '0;
            state_d = ST_POT_INIT;
          end
        end
      end
      ST_POT_INIT: begin
        pot_we = 1'b1;
        v_d    = v_q + NCW'(1);
        if (v_q == n_q - NCW'(1)) begin
          e_d     = '0;
          p_d     = '0;
          state_d = ST_BF_EDGE;
        end
      end
      ST_BF_EDGE: begin
        if (e_q == nedge_q) begin
          e_d = '0;
          if (p_q == n_q) begin
            if (cyc_q) begin
              state_d = ST_DONE;
            end else begin
              s_d       = '0;
              v_d       = '0;
              settled_d = '0;
              state_d   = ST_SRC_INIT;
            end
          end else begin
            p_d = p_q + NCW'(1);
          end
        end else begin
          state_d = ST_BF_POT;
        end
      end
      ST_BF_POT: begin
        pot_ra_a = NW'(erd.tail);
        pot_ra_b = NW'(erd.head);
        if (in_use(erd.tail, n_q) && in_use(erd.head, n_q)) begin
          hd_d    = NW'(erd.head);
          wt_d    = erd.weight;
          state_d = ST_BF_RELAX;
        end else begin
          e_d     = e_q + ECW'(1);
          state_d = ST_BF_EDGE;
        end
      end
      ST_BF_RELAX: begin
        // the extra pass after n relax passes only checks
        if (bf_cand < XW'(pot_rd_b_q)) begin
          if (p_q != n_q) begin
            pot_we   = 1'b1;
            pot_wa   = hd_q;
            pot_wdat = sat(bf_cand);
          end else begin
            cyc_d = 1'b1;
          end
        end
        e_d     = e_q + ECW'(1);
        state_d = ST_BF_EDGE;
      end
      ST_SRC_INIT: begin
        wd_we   = 1'b1;
        wd_wdat = (v_q[NW-1:0] == s_q) ? '0 : UNREACH;
        v_d     = v_q + NCW'(1);
        if (v_q == n_q - NCW'(1)) begin
          v_d        = '0;
          k_d        = '0;
          best_vld_d = 1'b0;
          state_d    = ST_SEL;
        end
      end
      ST_SEL: begin
        // scan reads node v, judges node v-1
        best_vld_d = fin_vld;
        best_v_d   = fin_v;
        best_d_d   = fin_d;
        v_d        = v_q + NCW'(1);
        if (v_q == n_q) begin
          v_d = '0;
          if (!fin_vld) begin
            state_d = ST_ROW;
          end else begin
            u_d              = fin_v;
            wdu_d            = fin_d;
            settled_d[fin_v] = 1'b1;
            e_d              = '0;
            state_d          = ST_RX_EDGE;
          end
        end
      end
      ST_RX_EDGE: begin
        pot_ra_a = u_q;
        if (e_q == nedge_q) begin
          v_d = '0;
          if (k_q == n_q - NCW'(1)) begin
            state_d = ST_ROW;
          end else begin
            k_d        = k_q + NCW'(1);
            best_vld_d = 1'b0;
            state_d    = ST_SEL;
          end
        end else begin
          state_d = ST_RX_READ;
        end
      end
      ST_RX_READ: begin
        pot_ra_a = u_q;
        pot_ra_b = NW'(erd.head);
        wd_ra    = NW'(erd.head);
        if ((CW'(erd.tail) == CW'(u_q)) && in_use(erd.head, n_q)) begin
          hd_d    = NW'(erd.head);
          wt_d    = erd.weight;
          state_d = ST_RX_RELAX;
        end else begin
          e_d     = e_q + ECW'(1);
          state_d = ST_RX_EDGE;
        end
      end
      ST_RX_RELAX: begin
        pot_ra_a = u_q;
        if (rx_cand < wd_rd_q) begin
          wd_we   = 1'b1;
          wd_wa   = hd_q;
          wd_wdat = rx_cand;
          if (hd_q == u_q) wdu_d = rx_cand;
        end
        e_d     = e_q + ECW'(1);
        state_d = ST_RX_EDGE;
      end
      ST_ROW: begin
        // restore d - h[s] + h[t] for node v-1
        if (v_q != '0) begin
          mat_we   = 1'b1;
          mat_wdat = (wd_rd_q == UNREACH) ? UNREACH :
                     sat(XW'(wd_rd_q) - XW'(pot_rd_a_q) + XW'(pot_rd_b_q));
        end
        v_d = v_q + NCW'(1);
        if (v_q == n_q) begin
          v_d = '0;
          if (NCW'(s_q) + NCW'(1) == n_q) begin
            mat_n_d = n_q;
            state_d = ST_DONE;
          end else begin
            s_d       = s_q + NW'(1);
            settled_d = '0;
            state_d   = ST_SRC_INIT;
          end
        end
      end
      ST_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d       = 1'b1;
          okind_d    = KIND_STATUS;
          osrc_d     = '0;
          odst_d     = '0;
          olen_d     = '0;
          oreach_d   = 1'b0;
          oneg_d     = cyc_q;
          cycfound_d = cyc_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      node_cfg_q <= NODE_COUNT_RST;
      n_q        <= '0;
      ecnt_q     <= '0;
      nedge_q    <= '0;
      e_q        <= '0;
      p_q        <= '0;
      v_q        <= '0;
      k_q        <= '0;
      cyc_q      <= 1'b0;
      cycfound_q <= 1'b0;
      mat_n_q    <= '0;
      best_vld_q <= 1'b0;
      settled_q  <= '0;
      q_pend_q   <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) node_cfg_q <= cfg_wdata_i;
      n_q        <= n_d;
      ecnt_q     <= ecnt_d;
      nedge_q    <= nedge_d;
      e_q        <= e_d;
      p_q        <= p_d;
      v_q        <= v_d;
      k_q        <= k_d;
      cyc_q      <= cyc_d;
      cycfound_q <= cycfound_d;
      mat_n_q    <= mat_n_d;
      best_vld_q <= best_vld_d;
      settled_q  <= settled_d;
      q_pend_q   <= q_pend_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    u_q      <= u_d;
    best_v_q <= best_v_d;
    best_d_q <= best_d_d;
    wdu_q    <= wdu_d;
    hd_q     <= hd_d;
    wt_q     <= wt_d;
    qa_q     <= qa_d;
    qb_q     <= qb_d;
    q_oor_q  <= q_oor_d;
    okind_q  <= okind_d;
    osrc_q   <= osrc_d;
    odst_q   <= odst_d;
    olen_q   <= olen_d;
    oreach_q <= oreach_d;
    oneg_q   <= oneg_d;
  end

  // potentials: one write, two reads
  always_ff @(posedge clk_i) begin
    if (pot_we) pot_mem[pot_wa] <= pot_wdat;
    pot_rd_a_q <= pot_mem[pot_ra_a];
    pot_rd_b_q <= pot_mem[pot_ra_b];
  end

  // working distances of the current source
  always_ff @(posedge clk_i) begin
    if (wd_we) wd_mem[wd_wa] <= wd_wdat;
    wd_rd_q <= wd_mem[wd_ra];
  end

  // result matrix, row stride 2^NW
  always_ff @(posedge clk_i) begin
    if (mat_we) mat_mem[mat_wa] <= mat_wdat;
    mat_rd_q <= mat_mem[mat_ra];
  end

  assign req_i.ready          = rdy;
  assign rsp_o.valid          = ov_q;
  assign rsp_o.kind           = okind_q;
  assign rsp_o.src_node       = osrc_q;
  assign rsp_o.dest_node      = odst_q;
  assign rsp_o.path_length    = olen_q;
  assign rsp_o.reachable      = oreach_q;
  assign rsp_o.negative_cycle = oneg_q;

  // a matrix read always lands in the output register next cycle
  a_query_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pend_q |=> ov_q && (okind_q == KIND_ANSWER))
    else $error("query answer not loaded");

  a_edge_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= ECW'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_status_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && (!ov_q || rsp_o.ready) |=>
      ov_q && (okind_q == KIND_STATUS) && (state_q == ST_IDLE))
    else $error("status response missing at end of run");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !req_i.ready)
    else $error("request taken during a run");

endmodule
`default_nettype wire

>>> hw/rtl/apsp_edge_mem.sv
`default_nettype none
// Edge list store: one write port, one registered read port.
module apsp_edge_mem import apsp_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire edge_t         wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output      edge_t         rdata_o
);

  edge_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire
